// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the base64 codec checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/b64sc_pkg.sv =====
// ----------------------------------------------------------------------------
// b64sc_pkg
// Types, constants and alphabet functions for the base64 stream codec.
// ----------------------------------------------------------------------------
`default_nettype none

package b64sc_pkg;

	localparam logic [7:0] PAD_CHAR = 8'h3D;
	localparam int SLOTS = 4;

	typedef struct packed {
		logic [7:0] in_value;
		logic       in_last;
	} b64sc_in_t;

	typedef struct packed {
		logic [7:0] out_value;
		logic       out_valid;
		logic       out_last;
		logic       bad_char;
	} b64sc_out_t;

	// One accepted item turned into up to four results.
	typedef struct packed {
		logic [1:0]             last_idx;
		logic [SLOTS-1:0][7:0]  chars;
		logic                   valid;
		logic                   last;
		logic                   bad;
	} b64sc_cmd_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} b64sc_sextet_t;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'h61 + {2'b00, v - 6'd26};
		end else if (v < 6'd62) begin
			c = 8'h30 + {2'b00, v - 6'd52};
		end else if (v == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

	function automatic b64sc_sextet_t sextet_of(input logic [7:0] c);
		b64sc_sextet_t s;
		s.ok  = 1'b1;
		s.val = 6'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			s.val = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			s.val = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			s.val = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			s.val = 6'd62;
		end else if (c == 8'h2F) begin
			s.val = 6'd63;
		end else begin
			s.ok = 1'b0;
		end
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/b64sc_front.sv =====
// ----------------------------------------------------------------------------
// b64sc_front
// Accepts items, keeps the message state and turns each item that has
// results into a command holding all of them.
// ----------------------------------------------------------------------------
`default_nettype none

module b64sc_front (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  b64sc_pkg::b64sc_in_t   in_item,
	input  wire                    cmd_full,
	input  wire                    cfg_wr_en,
	input  wire                    cfg_wr_data,
	output logic                   cmd_push,
	output b64sc_pkg::b64sc_cmd_t  cmd
);
	import b64sc_pkg::*;

	logic        mode_q;
	logic [11:0] acc_q;
	logic [3:0]  pend_q;
	logic [1:0]  cmf_q;
	logic        stop_q;

	logic [11:0] acc_d;
	logic [3:0]  pend_d;
	logic [1:0]  cmf_d;
	logic        stop_d;
	logic        has_result;

	logic          accept;
	logic [11:0]   acc_e;
	logic [5:0]    s0;
	logic [5:0]    s1;
	logic [5:0]    flush_s;
	logic [2:0]    n_pre;
	logic [1:0]    pads;
	logic [2:0]    total;
	b64sc_sextet_t sx;

	assign accept   = push && !cmd_full;
	assign cmd_push = accept && has_result;

	always_comb begin
		acc_d      = acc_q;
		pend_d     = pend_q;
		cmf_d      = cmf_q;
		stop_d     = stop_q;
		has_result = 1'b0;
		cmd        = '0;
		acc_e      = {acc_q[3:0], in_item.in_value};
		s0         = 6'd0;
		s1         = 6'd0;
		flush_s    = 6'd0;
		n_pre      = 3'd0;
		pads       = 2'd0;
		total      = 3'd0;
		sx         = sextet_of(in_item.in_value);

		if (!mode_q) begin
			acc_d = acc_e;
			case (pend_q)
				4'd0: begin
					s0     = acc_e[7:2];
					n_pre  = 3'd1;
					pend_d = 4'd2;
				end
				4'd2: begin
					s0     = acc_e[9:4];
					n_pre  = 3'd1;
					pend_d = 4'd4;
				end
				default: begin
					s0     = acc_e[11:6];
					s1     = acc_e[5:0];
					n_pre  = 3'd2;
					pend_d = 4'd0;
				end
			endcase
			cmd.chars[0] = b64_char(s0);
			cmd.chars[1] = b64_char(s1);
			cmf_d = cmf_q + n_pre[1:0];
			if (in_item.in_last) begin
				// Leftover bits are zero-filled on the right into one more character.
				if (pend_d != 4'd0) begin
					flush_s = (pend_d == 4'd2) ? {acc_e[1:0], 4'b0000} : {acc_e[3:0], 2'b00};
					for (int i = 0; i < SLOTS; i++) begin
						if (3'(i) == n_pre) begin
							cmd.chars[i] = b64_char(flush_s);
						end
					end
					n_pre = n_pre + 3'd1;
					cmf_d = cmf_d + 2'd1;
				end
				pads = 2'd0 - cmf_d;
			end
			total = n_pre + {1'b0, pads};
			if (total > 3'(SLOTS)) begin
				total = 3'(SLOTS);
			end
			for (int i = 0; i < SLOTS; i++) begin
				if (3'(i) >= n_pre && 3'(i) < total) begin
					cmd.chars[i] = PAD_CHAR;
				end
			end
			cmd.last_idx = 2'(total - 3'd1);
			cmd.valid    = 1'b1;
			cmd.last     = in_item.in_last;
			cmd.bad      = 1'b0;
			has_result   = 1'b1;
		end else begin
			if (!stop_q) begin
				if (!sx.ok) begin
					stop_d = 1'b1;
				end else begin
					acc_d = {acc_q[5:0], sx.val};
					case (pend_q)
						4'd0: begin
							pend_d = 4'd6;
						end
						4'd2: begin
							cmd.chars[0] = acc_d[7:0];
							cmd.valid    = 1'b1;
							pend_d       = 4'd0;
						end
						4'd4: begin
							cmd.chars[0] = acc_d[9:2];
							cmd.valid    = 1'b1;
							pend_d       = 4'd2;
						end
						default: begin
							cmd.chars[0] = acc_d[11:4];
							cmd.valid    = 1'b1;
							pend_d       = 4'd4;
						end
					endcase
				end
			end
			cmd.last_idx = 2'd0;
			cmd.last     = in_item.in_last;
			cmd.bad      = stop_d;
			has_result   = cmd.valid || in_item.in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			acc_q  <= '0;
			pend_q <= '0;
			cmf_q  <= '0;
			stop_q <= 1'b0;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
			acc_q  <= '0;
			pend_q <= '0;
			cmf_q  <= '0;
			stop_q <= 1'b0;
		end else if (accept) begin
			if (in_item.in_last) begin
				acc_q  <= '0;
				pend_q <= '0;
				cmf_q  <= '0;
				stop_q <= 1'b0;
			end else begin
				acc_q  <= acc_d;
				pend_q <= pend_d;
				cmf_q  <= cmf_d;
				stop_q <= stop_d;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/b64sc_fifo.sv =====
// ----------------------------------------------------------------------------
// b64sc_fifo
// Short command queue between the front and back parts of the codec.
// ----------------------------------------------------------------------------
`default_nettype none

module b64sc_fifo #(
	parameter int DEPTH = 2
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    wr_en,
	input  b64sc_pkg::b64sc_cmd_t  wr_data,
	output logic                   full,
	input  wire                    rd_en,
	output b64sc_pkg::b64sc_cmd_t  rd_data,
	output logic                   empty
);
	import b64sc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	b64sc_cmd_t      entries_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_wr;
	logic            do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/b64sc_back.sv =====
// ----------------------------------------------------------------------------
// b64sc_back
// Walks the results of the head command one per cycle into the output
// register, while that register is free to take one.
// ----------------------------------------------------------------------------
`default_nettype none

module b64sc_back (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cmd_empty,
	input  b64sc_pkg::b64sc_cmd_t  cmd,
	output logic                   cmd_pop,
	input  wire                    pop,
	output logic                   empty,
	output b64sc_pkg::b64sc_out_t  out_item
);
	import b64sc_pkg::*;

	logic       outv_q;
	b64sc_out_t out_q;
	logic [1:0] idx_q;
	logic       advance;
	logic       load;
	logic       last_slot;

	// The output register frees up when it is empty or being taken this cycle.
	assign advance   = !outv_q || pop;
	assign load      = advance && !cmd_empty;
	assign last_slot = (idx_q == cmd.last_idx);
	assign cmd_pop   = load && last_slot;
	assign empty     = !outv_q;
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outv_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (advance) begin
				outv_q <= !cmd_empty;
			end
			if (load) begin
				idx_q <= last_slot ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_value <= cmd.chars[idx_q];
			out_q.out_valid <= cmd.valid;
			out_q.out_last  <= cmd.last && last_slot;
			out_q.bad_char  <= cmd.bad;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/base64_stream_codec.sv =====
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming base64 encoder and decoder with a one-bit mode register.
// ----------------------------------------------------------------------------
// Items enter through a queue-style port: an item is taken on a clock edge
// with push high and full low. Results leave the same way: the oldest result
// sits on out_item while empty is low and is taken on an edge with pop high.
// cfg_wr_en writes cfg_wr_data into the mode (0 encode, 1 decode) and clears
// the message state; write it only while no item is in flight.
// The front part turns each item that has results into a command holding
// all of them in the cycle it is accepted; a command queue of CMD_DEPTH
// entries feeds the back part, which sends one result per cycle through an
// output register while the receiver keeps taking them. The first result of
// an item is loaded into that register once its command heads the queue and
// the register is free. Input is taken every cycle while the queue has room;
// when encoding, three bytes give four results, so the result port sets the rate.
// When the receiver stalls, the output register holds, the queue fills and
// full rises. Reset empties the queue and output register, selects encoding
// and clears the message state.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_codec #(
	parameter int CMD_DEPTH = 2
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	output logic                   full,
	input  b64sc_pkg::b64sc_in_t   in_item,
	output logic                   empty,
	input  wire                    pop,
	output b64sc_pkg::b64sc_out_t  out_item,
	input  wire                    cfg_wr_en,
	input  wire                    cfg_wr_data
);
	import b64sc_pkg::*;

	b64sc_cmd_t front_cmd;
	b64sc_cmd_t head_cmd;
	logic       cmd_push;
	logic       cmd_pop;
	logic       cmd_empty;

	b64sc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.in_item     (in_item),
		.cmd_full    (full),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd_push    (cmd_push),
		.cmd         (front_cmd)
	);

	b64sc_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (front_cmd),
		.full    (full),
		.rd_en   (cmd_pop),
		.rd_data (head_cmd),
		.empty   (cmd_empty)
	);

	b64sc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (head_cmd),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

// ===== rtl/b64sc_checker.sv =====
// ----------------------------------------------------------------------------
// b64sc_checker
// Port-level checks on the result channel of the base64 stream codec.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module b64sc_checker (
	input wire                    clk,
	input wire                    arst_n,
	input wire                    empty,
	input wire                    pop,
	input b64sc_pkg::b64sc_out_t  out_item
);
	import b64sc_pkg::*;

	logic res_void;
	logic res_zero_close;
	logic res_bad;
	logic res_empty_close;

	assign res_void        = !empty && !out_item.out_valid;
	assign res_zero_close  = out_item.out_last && (out_item.out_value == 8'h00);
	assign res_bad         = !empty && out_item.bad_char;
	assign res_empty_close = out_item.out_last && !out_item.out_valid;

	// A waiting result that is not taken stays in place.
	`ASSERT_NEXT(a_hold_on_stall, clk, arst_n, !empty && !pop, !empty && $stable(out_item))

	// A result without data only closes a message and carries a zero value.
	`ASSERT_SAME(a_empty_result_closes, clk, arst_n, res_void, res_zero_close)

	// A bad character is reported only on the closing result, which has no byte.
	`ASSERT_SAME(a_bad_on_close, clk, arst_n, res_bad, res_empty_close)

endmodule

bind base64_stream_codec b64sc_checker u_b64sc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.empty    (empty),
	.pop      (pop),
	.out_item (out_item)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the base64 stream codec in both modes.
// ----------------------------------------------------------------------------
// Directed messages cover padding, alphabet edges, bad characters and
// abandoned messages. Random traffic then alternates between encode and
// decode phases, all but one under random idling on both sides. A local prediction of
// the codec keeps a queue of the results due, and each popped result is
// checked field by field against the oldest one.
// ----------------------------------------------------------------------------
module testbench;
	import b64sc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 20;
	localparam int SETTLE_CYCLES = 4;
	localparam int GAP_PERCENT = 12;
	localparam int NOISE_PERCENT = 15;
	localparam int TARGET_ITEMS = 360;
	localparam int HOLD_CYCLES = 120;

	typedef enum {TAIL_NONE, TAIL_TWO_PAD, TAIL_ONE_PAD, TAIL_RAGGED} tail_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	b64sc_in_t in_item = '0;
	logic empty;
	logic pop = 1'b0;
	b64sc_out_t out_item;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;

	base64_stream_codec i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_item(in_item),
		.empty(empty),
		.pop(pop),
		.out_item(out_item),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	string symbols = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	b64sc_out_t due_results[$];
	int errors = 0;
	int items_sent = 0;
	int stall_cycles = 0;
	int hold_left = 0;
	int hold_requests = 0;
	int holds_done = 0;
	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;

	// Predicted codec state.
	logic        m_decode = 1'b0;
	logic [11:0] m_acc = '0;
	int          m_pend = 0;
	logic [1:0]  m_mod4 = '0;
	logic        m_stopped = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int symbol_value(input logic [7:0] c);
		int i;
		for (i = 0; i < 64; i++) begin
			if (symbols[i] == c) begin
				return i;
			end
		end
		return -1;
	endfunction

	task automatic clear_message_state;
		m_acc = '0;
		m_pend = 0;
		m_mod4 = '0;
		m_stopped = 1'b0;
	endtask

	task automatic predict_codec_output(input b64sc_in_t it);
		logic [7:0] outs [4];
		int n;
		int idx;
		int k;
		b64sc_out_t r;
		n = 0;
		if (!m_decode) begin
			m_acc = {m_acc[3:0], it.in_value};
			m_pend += 8;
			while (m_pend >= 6) begin
				outs[n] = symbols[6'(m_acc >> (m_pend - 6))];
				n++;
				m_pend -= 6;
			end
			m_mod4 = m_mod4 + 2'(n);
			if (it.in_last) begin
				// Flush the leftover bits, zero-filled on the right.
				if (m_pend > 0) begin
					outs[n] = symbols[6'(m_acc << (6 - m_pend))];
					n++;
					m_mod4 = m_mod4 + 2'd1;
				end
				while (m_mod4 != 2'd0 && n < 4) begin
					outs[n] = PAD_CHAR;
					n++;
					m_mod4 = m_mod4 + 2'd1;
				end
			end
			for (k = 0; k < n; k++) begin
				r.out_value = outs[k];
				r.out_valid = 1'b1;
				r.out_last = it.in_last && (k == n - 1);
				r.bad_char = 1'b0;
				due_results = {due_results, r};
			end
		end else begin
			if (!m_stopped) begin
				idx = symbol_value(it.in_value);
				if (idx < 0) begin
					m_stopped = 1'b1;
				end else begin
					m_acc = {m_acc[5:0], 6'(idx)};
					m_pend += 6;
					if (m_pend >= 8) begin
						outs[0] = 8'(m_acc >> (m_pend - 8));
						n = 1;
						m_pend -= 8;
					end
				end
			end
			// The last item always closes the message, with or without a byte.
			if (n == 1 || it.in_last) begin
				r.out_value = (n == 1) ? outs[0] : 8'd0;
				r.out_valid = (n == 1);
				r.out_last = it.in_last;
				r.bad_char = m_stopped;
				due_results = {due_results, r};
			end
		end
		if (it.in_last) begin
			clear_message_state();
		end
	endtask

	// Receiver: random pops, or a counted hold-off when one is requested.
	always @(negedge clk) begin
		if (holds_done != hold_requests) begin
			holds_done = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			pop = 1'b0;
			hold_left--;
		end else begin
			pop = !(rx_gaps && $urandom_range(99) < GAP_PERCENT);
		end
	end

	always @(posedge clk) begin : check_results
		b64sc_out_t want;
		if (arst_n && pop && !empty) begin
			if (due_results.size() == 0) begin
				$error("unexpected result: out_value %h", out_item.out_value);
				errors++;
			end else begin
				want = due_results.pop_front();
				if (out_item.out_value !== want.out_value) begin
					$error("out_value: expected %h, got %h", want.out_value, out_item.out_value);
					errors++;
				end
				if (out_item.out_valid !== want.out_valid) begin
					$error("out_valid: expected %b, got %b", want.out_valid, out_item.out_valid);
					errors++;
				end
				if (out_item.out_last !== want.out_last) begin
					$error("out_last: expected %b, got %b", want.out_last, out_item.out_last);
					errors++;
				end
				if (out_item.bad_char !== want.bad_char) begin
					$error("bad_char: expected %b, got %b", want.bad_char, out_item.bad_char);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("base64_stream_codec test failed");
				$finish;
			end
		end
	end

	// Push stays high after acceptance so that the next item can follow
	// back to back; drain_results lowers it.
	task automatic send_item(input logic [7:0] value, input logic last);
		b64sc_in_t it;
		it.in_value = value;
		it.in_last = last;
		@(negedge clk);
		while (tx_gaps && $urandom_range(99) < GAP_PERCENT) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		in_item = it;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		predict_codec_output(it);
		items_sent++;
	endtask

	task automatic drain_results;
		@(negedge clk);
		push = 1'b0;
		while (due_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic set_mode(input logic decode);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = decode;
		m_decode = decode;
		clear_message_state();
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic send_text(input string s, input bit close);
		int i;
		for (i = 0; i < s.len(); i++) begin
			send_item(s[i], close && (i == s.len() - 1));
		end
	endtask

	task automatic send_encode_message;
		int len;
		int i;
		len = $urandom_range(1, 7);
		for (i = 0; i < len; i++) begin
			send_item(8'($urandom_range(255)), i == len - 1);
		end
	endtask

	task automatic send_decode_message;
		logic [7:0] msg[$];
		tail_kind_t tail;
		int i;
		int extra;
		int quads;
		tail = tail_kind_t'($urandom_range(3));
		quads = $urandom_range(0, 3);
		for (i = 0; i < 4 * quads; i++) begin
			msg = {msg, symbols[$urandom_range(63)]};
		end
		case (tail)
			TAIL_TWO_PAD: begin
				msg = {msg, symbols[$urandom_range(63)]};
				msg = {msg, symbols[$urandom_range(63)]};
				msg = {msg, PAD_CHAR};
				msg = {msg, PAD_CHAR};
			end
			TAIL_ONE_PAD: begin
				repeat (3) msg = {msg, symbols[$urandom_range(63)]};
				msg = {msg, PAD_CHAR};
			end
			TAIL_RAGGED: begin
				extra = $urandom_range(1, 3);
				repeat (extra) msg = {msg, symbols[$urandom_range(63)]};
			end
			default: begin
			end
		endcase
		if (msg.size() == 0) begin
			msg = {msg, symbols[$urandom_range(63)]};
		end
		if ($urandom_range(99) < NOISE_PERCENT) begin
			msg[$urandom_range(msg.size() - 1)] = 8'($urandom_range(255));
		end
		for (i = 0; i < msg.size(); i++) begin
			send_item(msg[i], i == msg.size() - 1);
		end
	endtask

	// A message cut off before its last item; the next mode write drops it.
	task automatic send_open_fragment;
		int len;
		len = $urandom_range(1, 3);
		repeat (len) begin
			if (m_decode) begin
				send_item(symbols[$urandom_range(63)], 1'b0);
			end else begin
				send_item(8'($urandom_range(255)), 1'b0);
			end
		end
	endtask

	task automatic test_encode_directed;
		send_item(8'h00, 1'b1);
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b1);
		send_item(8'h80, 1'b0);
		send_item(8'h7F, 1'b0);
		send_item(8'hA5, 1'b1);
		// An open message is dropped by a write of the same mode.
		send_item(8'h12, 1'b0);
		set_mode(1'b0);
		send_item(8'h4D, 1'b1);
	endtask

	task automatic test_decode_directed;
		set_mode(1'b1);
		send_text("AZaz09+/", 1'b1);
		send_text("Q", 1'b1);
		send_text("T=z", 1'b1);
		send_item(8'hFF, 1'b1);
		send_text("TW", 1'b0);
		set_mode(1'b1);
	endtask

	task automatic test_full_stall;
		int i;
		set_mode(1'b0);
		tx_gaps = 1'b0;
		@(posedge clk);
		hold_requests++;
		for (i = 0; i < 24; i++) begin
			send_item(8'($urandom_range(255)), (i % 3) == 2);
		end
		tx_gaps = 1'b1;
		drain_results();
	endtask

	task automatic test_random_traffic;
		int phase;
		int msgs;
		phase = 0;
		while (items_sent < TARGET_ITEMS) begin
			set_mode(1'(phase % 2));
			// One phase runs with no idling on either side.
			tx_gaps = (phase != 2);
			rx_gaps = (phase != 2);
			for (msgs = 0; msgs < 8; msgs++) begin
				if (m_decode) begin
					send_decode_message();
				end else begin
					send_encode_message();
				end
				if ($urandom_range(5) == 0) begin
					drain_results();
				end
			end
			if ($urandom_range(2) == 0) begin
				send_open_fragment();
			end
			phase++;
		end
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_encode_directed();
		test_decode_directed();
		test_full_stall();
		test_random_traffic();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && due_results.size() == 0) begin
			$display("base64_stream_codec test passed");
		end else begin
			$display("base64_stream_codec test failed");
		end
		$finish;
	end

endmodule
